// ===== rtl/ckam_pkg.sv =====
// shared types, keyword table and codes for the command keyword matcher
`default_nettype none
package ckam_pkg;

	localparam int NUM_BYTES   = 7;
	localparam int NUM_ENTRIES = 17;
	localparam int NAME_LEN    = 7;
	localparam int LEN_W       = 3;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;

	typedef enum logic [3:0] {
		CODE_SYNTAX   = 4'd0,
		CODE_DIR      = 4'd1,
		CODE_ASSIGN   = 4'd2,
		CODE_BLOCK    = 4'd3,
		CODE_CD       = 4'd4,
		CODE_INIT     = 4'd5,
		CODE_MKDIR    = 4'd6,
		CODE_POSITION = 4'd7,
		CODE_RENAME   = 4'd8,
		CODE_RMDIR    = 4'd9,
		CODE_SCRATCH  = 4'd10,
		CODE_TIME     = 4'd11,
		CODE_USER     = 4'd12,
		CODE_EXT      = 4'd13
	} cmd_code_t;

	// keyword names in scan order, zero padded
	localparam logic [7:0] KW_TEXT [NUM_ENTRIES][NAME_LEN] = '{
		'{"A", "S", "S", "I", "G", "N", 8'h00},
		'{"B", "L", "O", "C", "K", 8'h00, 8'h00},
		'{"C", "O", "P", "Y", 8'h00, 8'h00, 8'h00},
		'{"C", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"C", "H", "D", "I", "R", 8'h00, 8'h00},
		'{"I", "N", "I", "T", 8'h00, 8'h00, 8'h00},
		'{"M", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"M", "K", "D", "I", "R", 8'h00, 8'h00},
		'{"M", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"R", "E", "N", "A", "M", "E", 8'h00},
		'{"R", "M", "D", "I", "R", 8'h00, 8'h00},
		'{"R", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "C", "R", "A", "T", "C", "H"},
		'{"T", "I", "M", "E", 8'h00, 8'h00, 8'h00},
		'{"U", "S", "E", "R", 8'h00, 8'h00, 8'h00},
		'{"X", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [LEN_W-1:0] KW_LEN [NUM_ENTRIES] = '{
		3'd6, 3'd5, 3'd4, 3'd2, 3'd5, 3'd4, 3'd2, 3'd5, 3'd2,
		3'd1, 3'd6, 3'd5, 3'd2, 3'd7, 3'd4, 3'd4, 3'd1
	};

	localparam cmd_code_t KW_CODE [NUM_ENTRIES] = '{
		CODE_ASSIGN, CODE_BLOCK, CODE_SYNTAX, CODE_CD, CODE_CD, CODE_INIT, CODE_SYNTAX,
		CODE_MKDIR, CODE_MKDIR, CODE_POSITION, CODE_RENAME, CODE_RMDIR, CODE_RMDIR,
		CODE_SCRATCH, CODE_TIME, CODE_USER, CODE_EXT
	};

	// per-byte compare results
	typedef struct packed {
		logic [NUM_ENTRIES-1:0][NAME_LEN-1:0] eq;
		logic [NUM_BYTES-1:0]                 letter;
		logic                                 dollar;
	} cmp_t;

	// per-entry match results
	typedef struct packed {
		logic [NUM_ENTRIES-1:0] hit;
		logic [LEN_W-1:0]       first_nl;
		logic                   dollar;
	} hit_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ckam_cmd_if.sv =====
// input channel: seven command bytes with valid/ready
`default_nettype none
interface ckam_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [7:0] byte2;
	logic [7:0] byte3;
	logic [7:0] byte4;
	logic [7:0] byte5;
	logic [7:0] byte6;

	modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
		input ready);
	modport sink (input valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/ckam_res_if.sv =====
// result channel: command code and match length with valid/ready
`default_nettype none
interface ckam_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] command_code;
	logic [2:0] match_length;

	modport source (output valid, command_code, match_length, input ready);
	modport sink (input valid, command_code, match_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/ckam_cmp_stage.sv =====
// stage 1: letter classes and byte compares against every keyword
`default_nettype none
module ckam_cmp_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ckam_cmd_if.sink         cmd,
	output ckam_pkg::cmp_t   data_s1,
	output logic             valid_s1,
	input  wire logic        ready_dn
);
	import ckam_pkg::*;

	logic [7:0] bytes [NUM_BYTES];
	cmp_t       cmp_d;

	assign bytes[0] = cmd.byte0;
	assign bytes[1] = cmd.byte1;
	assign bytes[2] = cmd.byte2;
	assign bytes[3] = cmd.byte3;
	assign bytes[4] = cmd.byte4;
	assign bytes[5] = cmd.byte5;
	assign bytes[6] = cmd.byte6;

	assign cmd.ready = !valid_s1 || ready_dn;

	always_comb begin
		cmp_d.dollar = (bytes[0] == CHAR_DOLLAR);
		for (int j = 0; j < NUM_BYTES; j++) begin
			cmp_d.letter[j] = is_letter(bytes[j]);
		end
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			for (int j = 0; j < NAME_LEN; j++) begin
				cmp_d.eq[e][j] = (bytes[j] == KW_TEXT[e][j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			data_s1 <= cmp_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ckam_match_stage.sv =====
// stage 2: per-keyword hit flags and the first non-letter position
`default_nettype none
module ckam_match_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ckam_pkg::cmp_t   data_s1,
	input  wire logic             valid_s1,
	output logic                  ready_s1,
	output ckam_pkg::hit_t        data_s2,
	output logic                  valid_s2,
	input  wire logic             ready_dn
);
	import ckam_pkg::*;

	logic [NUM_BYTES-1:0] prefix;
	hit_t                 hit_d;

	assign ready_s1 = !valid_s2 || ready_dn;

	always_comb begin
		// prefix[j]: bytes 0..j are all letters
		prefix[0] = data_s1.letter[0];
		for (int j = 1; j < NUM_BYTES; j++) begin
			prefix[j] = prefix[j-1] && data_s1.letter[j];
		end
		hit_d.first_nl = LEN_W'(NUM_BYTES);
		for (int j = NUM_BYTES - 1; j >= 0; j--) begin
			if (!data_s1.letter[j]) begin
				hit_d.first_nl = LEN_W'(j);
			end
		end
		// an entry fails on a mismatch inside both its name and the letter run
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			hit_d.hit[e] = 1'b1;
			for (int j = 0; j < NAME_LEN; j++) begin
				if ((j < int'(KW_LEN[e])) && prefix[j] && !data_s1.eq[e][j]) begin
					hit_d.hit[e] = 1'b0;
				end
			end
		end
		hit_d.dollar = data_s1.dollar;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			data_s2 <= hit_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ckam_pick_stage.sv =====
// stage 3: first hit in table order, length and code, output register
`default_nettype none
module ckam_pick_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ckam_pkg::hit_t   data_s2,
	input  wire logic             valid_s2,
	output logic                  ready_s2,
	ckam_res_if.source            res
);
	import ckam_pkg::*;

	logic             valid_s3;
	cmd_code_t        code_s3;
	logic [LEN_W-1:0] len_s3;
	logic             found;
	cmd_code_t        sel_code;
	logic [LEN_W-1:0] sel_len;
	cmd_code_t        code_d;
	logic [LEN_W-1:0] len_d;

	assign ready_s2 = !valid_s3 || res.ready;

	always_comb begin
		found    = 1'b0;
		sel_code = CODE_SYNTAX;
		sel_len  = '0;
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			if (!found && data_s2.hit[e]) begin
				found    = 1'b1;
				sel_code = KW_CODE[e];
				sel_len  = KW_LEN[e];
			end
		end
		// match ends where the name ends or the letter run ends
		if (data_s2.first_nl < sel_len) begin
			sel_len = data_s2.first_nl;
		end
		if (data_s2.dollar) begin
			code_d = CODE_DIR;
			len_d  = LEN_W'(1);
		end else if (!found || (sel_len == '0)) begin
			code_d = CODE_SYNTAX;
			len_d  = '0;
		end else begin
			code_d = sel_code;
			len_d  = sel_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			code_s3 <= code_d;
			len_s3  <= len_d;
		end
	end

	assign res.valid        = valid_s3;
	assign res.command_code = code_s3;
	assign res.match_length = len_s3;
endmodule
`default_nettype wire

// ===== rtl/command_keyword_abbrev_match.sv =====
// Command keyword matcher: takes the first seven bytes of a command string and
// returns the command code and the number of characters the keyword used.
// Names may be abbreviated at any non-letter; a leading '$' is the directory
// command. Three register stages (byte compare, per-keyword hit, pick and
// output register); a beat is accepted every cycle while stage 1 is empty or
// moves on, and its result passes through the compare and hit registers to
// the output register. Up to three beats are held. Stalls propagate back
// stage by stage, so empty stages still fill while the output waits.
`default_nettype none
module command_keyword_abbrev_match (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ckam_cmd_if.sink    cmd,
	ckam_res_if.source  res
);
	import ckam_pkg::*;

	cmp_t data_s1;
	logic valid_s1;
	logic ready_s1;
	hit_t data_s2;
	logic valid_s2;
	logic ready_s2;

	ckam_cmp_stage u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.data_s1  (data_s1),
		.valid_s1 (valid_s1),
		.ready_dn (ready_s1)
	);

	ckam_match_stage u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_s1  (data_s1),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.data_s2  (data_s2),
		.valid_s2 (valid_s2),
		.ready_dn (ready_s2)
	);

	ckam_pick_stage u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_s2  (data_s2),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.res      (res)
	);

	// an empty output register means the whole pipe can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> cmd.ready)
		else $error("input not ready with empty output");

	a_dir_length: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.command_code == CODE_DIR) |-> (res.match_length == 3'd1))
		else $error("dir result with wrong length");

	a_zero_len_syntax: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.match_length == 3'd0) |-> (res.command_code == CODE_SYNTAX))
		else $error("zero length with non-syntax code");

	a_dollar_to_dir: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ready_s2 && data_s2.dollar |=> (res.command_code == CODE_DIR))
		else $error("leading dollar not reported as dir");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.command_code <= CODE_EXT))
		else $error("command code out of range");
endmodule
`default_nettype wire
